[src/hds_pkg.sv]
package hds_pkg;

  // Field and register widths
  localparam int SampleW  = 16;
  localparam int IdxW     = 8;
  localparam int RateW    = 15;
  localparam int SizeW    = 9;
  localparam int CfgDataW = 15;
  localparam int CfgIdxW  = 2;

  localparam int DefMaxWidth  = 256;
  localparam int DefMaxHeight = 256;

  localparam logic [RateW-1:0]   RateReset   = 15'd655;
  localparam logic [SizeW-1:0]   WidthReset  = 9'd200;
  localparam logic [SizeW-1:0]   HeightReset = 9'd200;
  localparam logic [SampleW-1:0] HeatOne     = 16'd32768;

  // Arithmetic widths: lap = n+s+e+w-4c, rate is Q0.16
  localparam int FracW  = 16;
  localparam int LapW   = SampleW + 3;
  localparam int ProdW  = RateW + 1 + LapW;
  localparam int SumW   = ProdW + 1;
  localparam int DeltaW = SumW - FracW;
  localparam int ValW   = DeltaW + 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRate   = 2'd0,
    CfgWidth  = 2'd1,
    CfgHeight = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic [IdxW-1:0]    row;
    logic [IdxW-1:0]    col;
    logic               last;
    logic               done;
  } result_t;

endpackage

[src/heat_diffusion_stencil_step_top.sv]
// Channel  Dir  Handshake                 Word
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in       in   in_valid_i / in_stall_o    sample_i
// out      out  out_valid_o / out_stall_i  new_value_o, row_index_o, column_index_o,
//                                          last_in_run_o, frame_done_o
//
// One input word per cycle on rows above the last, given queue credits; each gives one
// result (row 0 gives none). Last-row words past column 0 give two results (three on
// the final word) through the one result slot into the multiplier pipeline, so the input
// stalls there until they issue. Results pass the Laplacian, product and queue registers.
// Reset clears counters, pipeline valids and the output queue; line stores are not cleared.
// out_stall_i only fills the four-entry output queue; the input stalls on queue credits.
module heat_diffusion_stencil_step_top #(
  parameter int MAX_WIDTH  = hds_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = hds_pkg::DefMaxHeight
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hds_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hds_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hds_pkg::SampleW-1:0]  sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hds_pkg::SampleW-1:0]  new_value_o,
  output logic [hds_pkg::IdxW-1:0]     row_index_o,
  output logic [hds_pkg::IdxW-1:0]     column_index_o,
  output logic                         last_in_run_o,
  output logic                         frame_done_o
);
  import hds_pkg::*;

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int RW        = $clog2(MAX_HEIGHT);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int HW        = $clog2(MAX_HEIGHT + 1);
  localparam int WCmpW     = (WW > SizeW) ? WW : SizeW;
  localparam int HCmpW     = (HW > SizeW) ? HW : SizeW;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic signed [SumW-1:0] RoundHalf = SumW'(1) <<< (FracW - 1);

  // ---------------- configuration ----------------
  logic [RateW-1:0] rate_q;
  logic [SizeW-1:0] width_q;
  logic [SizeW-1:0] height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= RateReset;
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgRate:   rate_q   <= cfg_data_i[RateW-1:0];
        CfgWidth:  width_q  <= cfg_data_i[SizeW-1:0];
        CfgHeight: height_q <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  logic [WCmpW-1:0] gw_ext;
  logic [HCmpW-1:0] gh_ext;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;

  always_comb begin
    gw_ext = WCmpW'(width_q);
    gh_ext = HCmpW'(height_q);
    if (gw_ext < WCmpW'(2)) begin
      w_eff = WW'(2);
    end else if (gw_ext > WCmpW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(gw_ext);
    end
    if (gh_ext < HCmpW'(2)) begin
      h_eff = HW'(2);
    end else if (gh_ext > HCmpW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(gh_ext);
    end
  end

  // ---------------- raster position ----------------
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          cs_q;  // store holding the center row: 0 = a, 1 = b
  logic          in_acc;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic          row_end;
  logic          last_row;
  logic [CW-1:0] east_addr;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign col_inc   = WW'(col_q) + WW'(1);
  assign row_inc   = HW'(row_q) + HW'(1);
  assign row_end   = col_inc >= w_eff;
  assign last_row  = (row_q != '0) && (row_inc >= h_eff);
  assign east_addr = (col_inc < w_eff) ? CW'(col_inc) : CW'(w_eff - WW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cs_q  <= 1'b0;
    end else if (in_acc) begin
      if (row_end) begin
        col_q <= '0;
        cs_q  <= !cs_q;
        row_q <= (row_inc >= h_eff) ? '0 : RW'(row_inc);
      end else begin
        col_q <= CW'(col_inc);
      end
    end
  end

  // ---------------- line stores ----------------
  // Port 0 reads the word's column, port 1 the east neighbor. The store not holding the
  // center row takes the new word; read-first gives the row above on port 0.
  logic [SampleW-1:0] mem_a [MAX_WIDTH];
  logic [SampleW-1:0] mem_b [MAX_WIDTH];
  logic [SampleW-1:0] a_rd0_q, a_rd1_q, b_rd0_q, b_rd1_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_rd0_q <= mem_a[col_q];
      a_rd1_q <= mem_a[east_addr];
      if (cs_q) begin
        mem_a[col_q] <= sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_rd0_q <= mem_b[col_q];
      b_rd1_q <= mem_b[east_addr];
      if (!cs_q) begin
        mem_b[col_q] <= sample_i;
      end
    end
  end

  // ---------------- word held for result issue ----------------
  logic [SampleW-1:0] x_q, xp1_q, xp2_q, wcen_q;
  logic               item_cs_q;
  logic [CW-1:0]      item_col_q;
  logic [RW-1:0]      item_row_q;
  logic [SampleW-1:0] cen_c, cen_e, oth_c;

  assign cen_c = item_cs_q ? b_rd0_q : a_rd0_q;
  assign cen_e = item_cs_q ? b_rd1_q : a_rd1_q;
  assign oth_c = item_cs_q ? a_rd0_q : b_rd0_q;

  // Words arrive in raster order, so the last two words and the previous center read
  // are the west cells of the current row whenever the column is nonzero.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q        <= sample_i;
      xp1_q      <= x_q;
      xp2_q      <= xp1_q;
      wcen_q     <= cen_c;
      item_cs_q  <= cs_q;
      item_col_q <= col_q;
      item_row_q <= row_q;
    end
  end

  // Pending results, issued lowest bit first:
  // bit 0 releases the row above, bit 1 the west cell of the last row, bit 2 the final cell.
  logic [2:0]            mask_q;
  logic [2:0]            sel;
  logic [2:0]            rest;
  logic                  issue;
  logic                  s1_done;
  logic                  credit_ok;
  logic [FifoCntW:0]     inflight;
  logic [FifoCntW-1:0]   cnt_q;
  logic                  v_p1_q, v_p2_q;

  assign inflight  = {1'b0, cnt_q} + (FifoCntW + 1)'(v_p1_q) + (FifoCntW + 1)'(v_p2_q);
  assign credit_ok = inflight < (FifoCntW + 1)'(FifoDepth);
  assign sel[0]    = mask_q[0];
  assign sel[1]    = mask_q[1] && !mask_q[0];
  assign sel[2]    = mask_q[2] && !mask_q[1] && !mask_q[0];
  assign rest      = mask_q & ~sel;
  assign issue     = (mask_q != '0) && credit_ok;
  assign s1_done   = issue && (rest == '0);
  assign in_stall_o = (mask_q != '0) && !s1_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (in_acc) begin
      mask_q <= {last_row && row_end, last_row && (col_q != '0), row_q != '0};
    end else if (issue) begin
      mask_q <= rest;
    end
  end

  // Operand select for the result being issued
  logic [SampleW-1:0] op_n, op_s, op_e, op_w, op_c;
  logic [IdxW-1:0]    op_row, op_col;
  logic               op_done;
  logic [LapW-1:0]    lap_d;
  logic               col_ge1, col_ge2;

  assign col_ge1 = item_col_q != '0;
  assign col_ge2 = item_col_q >= CW'(2);

  always_comb begin
    if (sel[0]) begin
      op_n    = (item_row_q == RW'(1)) ? cen_c : oth_c;  // top row mirrors itself
      op_s    = x_q;
      op_e    = cen_e;
      op_w    = col_ge1 ? wcen_q : cen_c;
      op_c    = cen_c;
      op_row  = IdxW'(item_row_q - RW'(1));
      op_col  = IdxW'(item_col_q);
      op_done = 1'b0;
    end else if (sel[1]) begin
      op_n    = wcen_q;
      op_s    = xp1_q;
      op_e    = x_q;
      op_w    = col_ge2 ? xp2_q : xp1_q;
      op_c    = xp1_q;
      op_row  = IdxW'(item_row_q);
      op_col  = IdxW'(item_col_q - CW'(1));
      op_done = 1'b0;
    end else begin
      op_n    = cen_c;
      op_s    = x_q;
      op_e    = x_q;
      op_w    = col_ge1 ? xp1_q : x_q;
      op_c    = x_q;
      op_row  = IdxW'(item_row_q);
      op_col  = IdxW'(item_col_q);
      op_done = 1'b1;
    end
    lap_d = LapW'(op_n) + LapW'(op_s) + LapW'(op_e) + LapW'(op_w) - (LapW'(op_c) << 2);
  end

  // ---------------- arithmetic pipeline ----------------
  logic signed [LapW-1:0]  lap_q;
  logic [SampleW-1:0]      p1_c_q, p2_c_q;
  logic [IdxW-1:0]         p1_row_q, p1_col_q, p2_row_q, p2_col_q;
  logic                    p1_last_q, p1_done_q, p2_last_q, p2_done_q;
  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p1_q <= 1'b0;
      v_p2_q <= 1'b0;
    end else begin
      v_p1_q <= issue;
      v_p2_q <= v_p1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lap_q     <= lap_d;
    p1_c_q    <= op_c;
    p1_row_q  <= op_row;
    p1_col_q  <= op_col;
    p1_last_q <= rest == '0;
    p1_done_q <= op_done;

    prod_q    <= $signed({1'b0, rate_q}) * lap_q;
    p2_c_q    <= p1_c_q;
    p2_row_q  <= p1_row_q;
    p2_col_q  <= p1_col_q;
    p2_last_q <= p1_last_q;
    p2_done_q <= p1_done_q;
  end

  // Round to nearest, ties up: floor((prod + 2^15) / 2^16), then add and clamp
  logic signed [SumW-1:0]   rsum;
  logic signed [DeltaW-1:0] delta;
  logic signed [ValW-1:0]   val;
  result_t                  res_d;

  always_comb begin
    rsum  = SumW'(prod_q) + RoundHalf;
    delta = rsum[SumW-1:FracW];
    val   = $signed(ValW'(p2_c_q)) + ValW'(delta);
    if (val[ValW-1]) begin
      res_d.value = '0;
    end else if (val > $signed(ValW'(HeatOne))) begin
      res_d.value = HeatOne;
    end else begin
      res_d.value = val[SampleW-1:0];
    end
    res_d.row  = p2_row_q;
    res_d.col  = p2_col_q;
    res_d.last = p2_last_q;
    res_d.done = p2_done_q;
  end

  // ---------------- output queue ----------------
  result_t             fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic                push, pop;
  result_t             head;

  assign push        = v_p2_q;
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign head        = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + FifoCntW'(1);
        2'b01:   cnt_q <= cnt_q - FifoCntW'(1);
        default: ;
      endcase
    end
  end

  assign new_value_o    = head.value;
  assign row_index_o    = head.row;
  assign column_index_o = head.col;
  assign last_in_run_o  = head.last;
  assign frame_done_o   = head.done;

endmodule

[src/hds_checker.sv]
module hds_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [hds_pkg::SampleW-1:0] new_value_o,
  input logic [hds_pkg::IdxW-1:0]    row_index_o,
  input logic [hds_pkg::IdxW-1:0]    column_index_o,
  input logic                        last_in_run_o,
  input logic                        frame_done_o
);

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(new_value_o) &&
      $stable(row_index_o) && $stable(column_index_o) && $stable(last_in_run_o) &&
      $stable(frame_done_o))
  else $error("stalled result word changed");

  // The final cell of a frame always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> last_in_run_o)
  else $error("frame end not last in run");

  // Results of one input word leave back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_in_run_o |=> out_valid_o)
  else $error("gap inside a run of results");

  // Nothing is shown right after reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
  else $error("result word after reset");

endmodule

bind heat_diffusion_stencil_step_top hds_checker u_hds_checker (.*);

[tb/heat_diffusion_stencil_step_top_test.sv]
module heat_diffusion_stencil_step_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hds_pkg::*;

  localparam int HalfPeriod   = 4;
  localparam int ResetCycles  = 10;
  localparam int SettleCycles = 12;
  localparam int StallLimit   = 4000;
  localparam int GridMax      = 256;
  localparam int HeatMax      = 32768;
  localparam int RandomCells  = 40;

  // index 3 maps to no register; writes there must be ignored
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index    = CfgRate;
  logic [CfgDataW-1:0] cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [SampleW-1:0]  sample       = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [SampleW-1:0]  new_value;
  logic [IdxW-1:0]     row_index;
  logic [IdxW-1:0]     column_index;
  logic                last_in_run;
  logic                frame_done;

  heat_diffusion_stencil_step_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .new_value_o    (new_value),
    .row_index_o    (row_index),
    .column_index_o (column_index),
    .last_in_run_o  (last_in_run),
    .frame_done_o   (frame_done)
  );

  always #HalfPeriod clk = ~clk;

  // grid model state
  logic [SampleW-1:0] heat_rows [2][GridMax];
  bit                 center_sel = 1'b0;
  int unsigned        row_pos    = 0;
  int unsigned        col_pos    = 0;
  logic [RateW-1:0]   rate_q     = RateReset;
  logic [SizeW-1:0]   width_q    = WidthReset;
  logic [SizeW-1:0]   height_q   = HeightReset;
  result_t            pending_cells [$];

  int errors        = 0;
  int samples_sent  = 0;
  int cells_checked = 0;
  int cfg_writes    = 0;
  int frames_sent   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles   = 0;

  function automatic int unsigned fit_size(logic [SizeW-1:0] v);
    if (v < 2) return 2;
    if (v > GridMax) return GridMax;
    return v;
  endfunction

  // c + rate*(n+s+e+w-4c), product rounded half up to Q1.15, clamped to 0..1.0
  function automatic logic [SampleW-1:0] diffuse(int unsigned n, int unsigned s, int unsigned e,
                                                 int unsigned w, int unsigned c);
    longint lap;
    longint delta;
    longint v;
    lap   = longint'(n) + longint'(s) + longint'(e) + longint'(w) - 4 * longint'(c);
    delta = (longint'(rate_q) * lap + 32768) >>> 16;
    v     = longint'(c) + delta;
    if (v < 0) v = 0;
    if (v > HeatMax) v = HeatMax;
    return v[SampleW-1:0];
  endfunction

  function automatic result_t make_update(logic [SampleW-1:0] v, int unsigned r, int unsigned c,
                                          bit fin);
    result_t upd;
    upd.value = v;
    upd.row   = IdxW'(r);
    upd.col   = IdxW'(c);
    upd.last  = 1'b0;
    upd.done  = fin;
    return upd;
  endfunction

  // one accepted word: release the cells it completes, store it, move the raster position
  task automatic advance_grid(input logic [SampleW-1:0] x);
    int unsigned w, h, c, r, cen, oth;
    int unsigned ce, no, we, ea;
    result_t hits [$];
    w   = fit_size(width_q);
    h   = fit_size(height_q);
    c   = col_pos % GridMax;
    r   = row_pos;
    cen = center_sel;
    oth = center_sel ? 0 : 1;
    if (r >= 1) begin
      ce = heat_rows[cen][c];
      no = (r == 1) ? ce : heat_rows[oth][c];
      we = heat_rows[cen][(c >= 1) ? c - 1 : 0];
      ea = heat_rows[cen][(c + 1 < w) ? c + 1 : w - 1];
      hits.push_back(make_update(diffuse(no, x, ea, we, ce), r - 1, c, 1'b0));
    end
    heat_rows[oth][c] = x;
    // bottom row: no row below, so release it as the word to the right arrives
    if (r >= 1 && r >= h - 1) begin
      if (c >= 1) begin
        ce = heat_rows[oth][c - 1];
        no = heat_rows[cen][c - 1];
        we = heat_rows[oth][(c >= 2) ? c - 2 : 0];
        hits.push_back(make_update(diffuse(no, ce, x, we, ce), r, c - 1, 1'b0));
      end
      if (c >= w - 1) begin
        no = heat_rows[cen][c];
        we = (c >= 1) ? heat_rows[oth][c - 1] : x;
        hits.push_back(make_update(diffuse(no, x, x, we, x), r, c, 1'b1));
      end
    end
    if (hits.size() > 0) hits[hits.size() - 1].last = 1'b1;
    foreach (hits[i]) pending_cells.push_back(hits[i]);
    if (c + 1 >= w) begin
      col_pos    = 0;
      center_sel = ~center_sel;
      row_pos    = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_cells
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_cells.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got value %0d at (%0d,%0d)",
                   $time, new_value, row_index, column_index);
        end else begin
          want = pending_cells.pop_front();
          check_field("new_value", want.value, new_value);
          check_field("row_index", want.row, row_index);
          check_field("column_index", want.col, column_index);
          check_field("last_in_run", want.last, last_in_run);
          check_field("frame_done", want.done, frame_done);
          cells_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // no handshake on any channel for too long means the block is hung
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, StallLimit);
      $display("heat_diffusion_stencil_step_top_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [SampleW-1:0] heat_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 85) return SampleW'($urandom_range(HeatMax));
    if (pick < 95) return SampleW'($urandom);
    case (pick % 3)
      0:       return '0;
      1:       return HeatOne;
      default: return '1;
    endcase
  endfunction

  // valid is left high after acceptance; drain_grid or an idle draw in the next call drops it
  task automatic push_sample(input logic [SampleW-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= x;
    do @(posedge clk); while (in_stall);
    advance_grid(x);
    samples_sent++;
  endtask

  task automatic send_cells(input int n);
    repeat (n) push_sample(heat_sample());
  endtask

  // row-0 words give no result, so let the pipeline settle after the last one lands
  task automatic drain_grid();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgRate:   rate_q   = data[RateW-1:0];
      CfgWidth:  width_q  = data[SizeW-1:0];
      CfgHeight: height_q = data[SizeW-1:0];
      default:   ;
    endcase
    cfg_writes++;
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(input int unsigned rate, input int unsigned w, input int unsigned h);
    cfg_write(CfgRate, CfgDataW'(rate));
    cfg_write(CfgWidth, CfgDataW'(w));
    cfg_write(CfgHeight, CfgDataW'(h));
    cfg_release();
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // one small frame at the power-up rate
  task automatic test_reset_rate();
    set_idling(30, 52);
    cfg_write(CfgWidth, 15'd5);
    cfg_write(CfgHeight, 15'd4);
    cfg_release();
    send_cells(5 * 4);
    frames_sent++;
    drain_grid();
  endtask

  task automatic test_field_extremes();
    logic [SampleW-1:0] grid3 [9] = '{16'd0, 16'd32768, 16'hFFFF, 16'd1, 16'h7FFF,
                                      16'h8000, 16'd32768, 16'd0, 16'hFFFF};
    logic [SampleW-1:0] grid2 [4] = '{16'hFFFF, 16'd0, 16'd32768, 16'd0};
    set_idling(30, 52);
    set_grid(16384, 3, 3);
    foreach (grid3[i]) push_sample(grid3[i]);
    frames_sent++;
    drain_grid();
    // sizes below two saturate up, rate past the stable bound is used as written
    cfg_write(CfgRate, 15'h7FFF);
    cfg_write(CfgWidth, 15'd0);
    cfg_write(CfgHeight, 15'd1);
    cfg_write(CfgSpare, 15'h7FFF);
    cfg_release();
    foreach (grid2[i]) push_sample(grid2[i]);
    frames_sent++;
    drain_grid();
    // upper data bits are dropped on size registers
    cfg_write(CfgRate, 15'd0);
    cfg_write(CfgWidth, 15'h7E02);
    cfg_write(CfgHeight, 15'h7C02);
    cfg_release();
    foreach (grid2[i]) push_sample(~grid2[i]);
    frames_sent++;
    drain_grid();
  endtask

  task automatic test_wide_grid();
    set_idling(52, 30);
    set_grid($urandom_range(16384), 20, 2);
    send_cells(20 * 2);
    frames_sent++;
    drain_grid();
  endtask

  task automatic test_tall_grid();
    set_idling(52, 30);
    set_grid($urandom_range(16384), 2, 10);
    send_cells(2 * 10);
    frames_sent++;
    drain_grid();
  endtask

  // shrink only, so every neighbour read hits a column written this frame
  task automatic test_resize_mid_frame();
    set_idling(0, 0);
    set_grid(4096, 8, 8);
    send_cells(8 + 8 + 6);
    drain_grid();
    cfg_write(CfgWidth, 15'd4);
    cfg_release();
    send_cells(1 + 4 + 4);
    drain_grid();
    cfg_write(CfgHeight, 15'd3);
    cfg_release();
    send_cells(4);
    send_cells(4 * 3);
    frames_sent += 2;
    drain_grid();
  endtask

  task automatic test_random_frames();
    int sent;
    int w, h, rate, n, fr;
    sent = 0;
    fr   = 0;
    while (sent < RandomCells) begin
      if (sent < RandomCells / 3)          set_idling(30, 52);
      else if (sent < 2 * RandomCells / 3) set_idling(52, 30);
      else                                 set_idling(0, 0);
      rate = ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(16384);
      w    = $urandom_range(2, 7);
      h    = $urandom_range(2, 4);
      set_grid(rate, w, h);
      n = w * h;
      if (fr == 2) begin
        // hold the stream mid-frame until every pending cell is out
        send_cells(n / 2);
        drain_grid();
        send_cells(n - n / 2);
      end else begin
        send_cells(n);
      end
      drain_grid();
      sent += n;
      fr++;
      frames_sent++;
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_rate();
    test_field_extremes();
    test_wide_grid();
    test_tall_grid();
    test_resize_mid_frame();
    test_random_frames();
    drain_grid();
    $display("Streamed %0d cells over %0d frames: power-up rate, saturated sizes, grids up to",
             samples_sent, frames_sent);
    $display("20 wide and 10 tall, mid-frame shrink, rates 0 to 0x7fff; %0d updates checked, %0d register writes",
             cells_checked, cfg_writes);
    if (errors == 0) begin
      $display("heat_diffusion_stencil_step_top_test OK");
    end else begin
      $display("heat_diffusion_stencil_step_top_test NOT OK");
    end
    $finish;
  end

endmodule
